[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file sal_chk.sv.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SAL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition on one edge implies a consequence on the next edge.
`define SAL_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/sal_pkg.sv]
// Shared types, sizes and helpers for the set-associative LRU lookup.
// Used by every module of the block but sal_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

	localparam int NUM_SETS = 64;
	localparam int NUM_WAYS = 4;
	localparam int TAG_BITS = 20;

	localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	localparam int SET_IN_W = 6;
	localparam int TAG_IN_W = 20;
	localparam int SET_IN_N = 1 << SET_IN_W;

	typedef logic [SET_W-1:0]    set_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [RANK_W-1:0]   rank_t;

	typedef enum logic [1:0] {
		KIND_HIT      = 2'd0,
		KIND_COLD     = 2'd1,
		KIND_CONFLICT = 2'd2
	} kind_t;

	typedef struct packed {
		set_t set;
		tag_t tag;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} fq_head_t;

	typedef struct packed {
		rank_t way;
		kind_t kind;
	} res_t;

	// Wrap an input set index onto the sets present, as a small table.
	function automatic set_t wrap_set(input logic [SET_IN_W-1:0] v);
		set_t r;
		r = '0;
		for (int i = 0; i < SET_IN_N; i++) begin
			if (v == SET_IN_W'(i)) begin
				r = SET_W'(i % NUM_SETS);
			end
		end
		return r;
	endfunction

	// Keep the low tag bits that are stored and compared.
	function automatic tag_t fit_tag(input logic [TAG_IN_W-1:0] v);
		return TAG_BITS'(v);
	endfunction

endpackage

`default_nettype wire

[rtl/core/sal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

[rtl/core/sal_front.sv]
// Front end: takes input beats, wraps set and tag, holds them in a two-entry queue.
// Depends on sal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sal_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [5:0]        set_index,
	input  wire logic [19:0]       tag,
	output sal_pkg::fq_head_t      head,
	input  wire logic              take
);
	sal_pkg::req_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = take && (cnt_q != 2'd0);

	assign head.valid = (cnt_q != 2'd0);
	assign head.req   = ent_q[rd_ptr_q];

	// Hold wrapped requests
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q].set <= sal_pkg::wrap_set(set_index);
			ent_q[wr_ptr_q].tag <= sal_pkg::fit_tag(tag);
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

`default_nettype wire

[rtl/core/sal_back.sv]
// Back end: reads the set, resolves hit or miss, updates LRU order, queues results.
// Depends on sal_pkg and sal_ram.
`timescale 1ns / 1ps
`default_nettype none

module sal_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sal_pkg::fq_head_t head,
	output logic                   take,
	output logic                   empty,
	input  wire logic              pop,
	output logic [1:0]             way,
	output logic [1:0]             access_kind
);
	localparam int NW    = sal_pkg::NUM_WAYS;
	localparam int RW    = sal_pkg::RANK_W;
	localparam int TB    = sal_pkg::TAG_BITS;
	localparam int NS    = sal_pkg::NUM_SETS;
	localparam int ROW_R = NW * RW;
	localparam int ROW_T = NW * TB;

	// State that reset clears at once
	logic [NS-1:0][NW-1:0] valid_q;
	logic [NS-1:0]         touched_q;

	// Lookup stage
	logic              v_s1;
	sal_pkg::req_t     req_s1;
	logic [NW-1:0]     valid_s1;
	logic              touched_s1;

	logic [ROW_R-1:0]  rank_rd;
	logic [ROW_T-1:0]  tag_rd;

	// Result queue
	sal_pkg::res_t     res_q [2];
	logic              rwr_q;
	logic              rrd_q;
	logic [1:0]        rcnt_q;
	logic              do_rpop;

	// Resolve signals
	logic [NW-1:0][RW-1:0] ranks;
	logic [NW-1:0][RW-1:0] ranks_new;
	logic [NW-1:0][TB-1:0] tags;
	logic [NW-1:0][TB-1:0] tags_new;
	logic [RW:0]           best;
	logic [RW-1:0]         pick;
	logic [RW-1:0]         old_rank;
	sal_pkg::kind_t        kind;
	logic                  miss;

	assign take    = head.valid && !v_s1 && (rcnt_q != 2'd2);
	assign do_rpop = pop && !empty;

	sal_ram #(.WIDTH(ROW_R), .DEPTH(NS)) u_rank_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (req_s1.set),
		.wdata (ranks_new),
		.re    (take),
		.raddr (head.req.set),
		.rdata (rank_rd)
	);

	sal_ram #(.WIDTH(ROW_T), .DEPTH(NS)) u_tag_ram (
		.clk   (clk),
		.we    (v_s1 && miss),
		.waddr (req_s1.set),
		.wdata (tags_new),
		.re    (take),
		.raddr (head.req.set),
		.rdata (tag_rd)
	);

	// Resolve hit, cold miss or conflict miss and the new order
	always_comb begin
		tags = tag_rd;
		for (int w = 0; w < NW; w++) begin
			ranks[w] = touched_s1 ? rank_rd[w*RW +: RW] : RW'(w);
		end
		best = (RW+1)'(NW);
		pick = '0;
		kind = sal_pkg::KIND_HIT;
		for (int w = 0; w < NW; w++) begin
			if (valid_s1[w] && tags[w] == req_s1.tag && {1'b0, ranks[w]} < best) begin
				best = {1'b0, ranks[w]};
				pick = RW'(w);
			end
		end
		if (best == (RW+1)'(NW)) begin
			kind = sal_pkg::KIND_COLD;
			for (int w = 0; w < NW; w++) begin
				if (!valid_s1[w] && {1'b0, ranks[w]} < best) begin
					best = {1'b0, ranks[w]};
					pick = RW'(w);
				end
			end
			if (best == (RW+1)'(NW)) begin
				kind = sal_pkg::KIND_CONFLICT;
				for (int w = 0; w < NW; w++) begin
					if (ranks[w] == RW'(NW - 1)) begin
						pick = RW'(w);
					end
				end
			end
		end
		miss     = (kind != sal_pkg::KIND_HIT);
		old_rank = ranks[pick];
		for (int w = 0; w < NW; w++) begin
			ranks_new[w] = (ranks[w] < old_rank) ? ranks[w] + RW'(1) : ranks[w];
		end
		ranks_new[pick] = '0;
		tags_new        = tags;
		tags_new[pick]  = req_s1.tag;
	end

	// Hold the request while the set is read; queue each resolved result
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1     <= head.req;
			valid_s1   <= valid_q[head.req.set];
			touched_s1 <= touched_q[head.req.set];
		end
		if (v_s1) begin
			res_q[rwr_q].way  <= pick;
			res_q[rwr_q].kind <= kind;
		end
	end

	// Advance control, mark lines and sets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			valid_q   <= '0;
			touched_q <= '0;
			rwr_q     <= 1'b0;
			rrd_q     <= 1'b0;
			rcnt_q    <= 2'd0;
		end else begin
			v_s1 <= take;
			if (v_s1) begin
				touched_q[req_s1.set] <= 1'b1;
				if (miss) begin
					valid_q[req_s1.set][pick] <= 1'b1;
				end
				rwr_q <= !rwr_q;
			end
			if (do_rpop) begin
				rrd_q <= !rrd_q;
			end
			rcnt_q <= rcnt_q + {1'b0, v_s1} - {1'b0, do_rpop};
		end
	end

	assign empty       = (rcnt_q == 2'd0);
	assign way         = 2'(res_q[rrd_q].way);
	assign access_kind = res_q[rrd_q].kind;
endmodule

`default_nettype wire

[rtl/core/set_assoc_lru_lookup.sv]
// Top level of the set-associative cache lookup with true-LRU replacement.
// Depends on sal_pkg, sal_front, sal_back (and sal_ram through sal_back).
//
//  channel   handshake        beat fields
//  input     push / full      set_index, tag
//  result    pop / empty      way, access_kind
//
// Each beat passes the back end in two steps: a read of the set's tag and
// rank rows from RAM, then a resolve that writes them back; a new beat enters
// only after the previous one wrote back.
// A result passes the input queue, the lookup stage and the result queue before it shows on the outputs.
// Reset clears valid bits and queue state at once; no clearing pass.
// A full result queue stalls the back end; the input queue then fills.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_lookup (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [5:0]  set_index,
	input  wire logic [19:0] tag,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       way,
	output logic [1:0]       access_kind
);
	sal_pkg::fq_head_t head;
	logic              take;

	sal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.set_index (set_index),
		.tag       (tag),
		.head      (head),
		.take      (take)
	);

	sal_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.take        (take),
		.empty       (empty),
		.pop         (pop),
		.way         (way),
		.access_kind (access_kind)
	);
endmodule

`default_nettype wire

[rtl/core/sal_chk.sv]
// Port-level checker for set_assoc_lru_lookup, bound to the top level.
// Depends on assert_macros.svh and sal_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sal_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [1:0] way,
	input wire logic [1:0] access_kind
);
	`SAL_ASSERT(a_kind_legal, !empty |-> (access_kind != 2'd3), "illegal access kind")
	`SAL_ASSERT(a_way_range, !empty |-> (32'(way) < sal_pkg::NUM_WAYS), "way out of range")
	`SAL_ASSERT_NEXT(a_res_stays, !empty && !pop, !empty, "result withdrawn")
	`SAL_ASSERT_NEXT(a_res_holds, !empty && !pop, $stable(way) && $stable(access_kind), "moved")
endmodule

bind set_assoc_lru_lookup sal_chk u_sal_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.way         (way),
	.access_kind (access_kind)
);

`default_nettype wire

[dv/tb_set_assoc_lru_lookup.sv]
// Self-checking testbench for set_assoc_lru_lookup: random and directed cache accesses.
// Predicts way and hit/cold/conflict kind with a true-LRU model; depends on sal_pkg and the RTL.
`timescale 1ns / 1ps

module tb_set_assoc_lru_lookup;

	typedef struct {
		logic [5:0]  set_index;
		logic [19:0] tag;
	} access_t;

	typedef struct {
		logic [1:0]      way;
		sal_pkg::kind_t  kind;
	} lookup_t;

	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [5:0]  set_index;
	logic [19:0] tag;
	logic        empty;
	logic        pop;
	logic [1:0]  way;
	logic [1:0]  access_kind;

	access_t pending_accesses[$];
	lookup_t expected_lookups[$];

	// shadow copy of the cache directory
	logic        shadow_valid[sal_pkg::NUM_SETS][sal_pkg::NUM_WAYS];
	logic [19:0] shadow_tag[sal_pkg::NUM_SETS][sal_pkg::NUM_WAYS];
	int          shadow_rank[sal_pkg::NUM_SETS][sal_pkg::NUM_WAYS];

	int  push_idle_pct;
	int  pop_idle_pct;
	bit  push_hold;
	int  error_count;
	int  watchdog;
	int  beats_in;
	int  beats_out;
	int  kind_seen[3];
	bit  stimulus_done;

	set_assoc_lru_lookup uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.set_index(set_index),
		.tag(tag),
		.empty(empty),
		.pop(pop),
		.way(way),
		.access_kind(access_kind)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Resolve one access against the shadow directory and update it.
	function automatic lookup_t predict_lookup(access_t a);
		lookup_t r;
		int s;
		int best;
		int pick;
		int old;
		s = a.set_index % sal_pkg::NUM_SETS;
		best = sal_pkg::NUM_WAYS;
		pick = 0;
		for (int w = 0; w < sal_pkg::NUM_WAYS; w++) begin
			if (shadow_valid[s][w] && shadow_tag[s][w] == a.tag && shadow_rank[s][w] < best) begin
				best = shadow_rank[s][w];
				pick = w;
			end
		end
		if (best < sal_pkg::NUM_WAYS) begin
			r.kind = sal_pkg::KIND_HIT;
		end else begin
			for (int w = 0; w < sal_pkg::NUM_WAYS; w++) begin
				if (!shadow_valid[s][w] && shadow_rank[s][w] < best) begin
					best = shadow_rank[s][w];
					pick = w;
				end
			end
			if (best < sal_pkg::NUM_WAYS) begin
				r.kind = sal_pkg::KIND_COLD;
			end else begin
				r.kind = sal_pkg::KIND_CONFLICT;
				for (int w = 0; w < sal_pkg::NUM_WAYS; w++) begin
					if (shadow_rank[s][w] == sal_pkg::NUM_WAYS - 1) pick = w;
				end
			end
			shadow_valid[s][pick] = 1'b1;
			shadow_tag[s][pick] = a.tag;
		end
		old = shadow_rank[s][pick];
		for (int w = 0; w < sal_pkg::NUM_WAYS; w++) begin
			if (shadow_rank[s][w] < old) shadow_rank[s][w]++;
		end
		shadow_rank[s][pick] = 0;
		r.way = pick[1:0];
		return r;
	endfunction

	function automatic void add_access(logic [5:0] s, logic [19:0] t);
		access_t a;
		a.set_index = s;
		a.tag = t;
		pending_accesses.push_back(a);
	endfunction

	// Drive input beats from the pending queue; hold off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			set_index <= '0;
			tag <= '0;
		end else begin
			access_t a;
			if (push && !full) begin
				expected_lookups.push_back(predict_lookup('{set_index, tag}));
				void'(pending_accesses.pop_front());
				beats_in++;
			end
			if ((!push || !full) && pending_accesses.size() > 0 && !push_hold
					&& $urandom_range(99) >= push_idle_pct) begin
				a = pending_accesses[0];
				push <= 1'b1;
				set_index <= a.set_index;
				tag <= a.tag;
			end else if (!push || !full) begin
				push <= 1'b0;
				set_index <= 6'($urandom);
				tag <= 20'($urandom);
			end
		end
	end

	// Check result beats against the oldest prediction; random stalls on pop.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			lookup_t e;
			if (pop && !empty) begin
				beats_out++;
				if (expected_lookups.size() == 0) begin
					$display("%0t: unexpected result way=%0d kind=%0d", $time, way, access_kind);
					error_count++;
				end else begin
					e = expected_lookups.pop_front();
					kind_seen[e.kind]++;
					if (way !== e.way) begin
						$display("%0t: way expected %0d actual %0d", $time, e.way, way);
						error_count++;
					end
					if (access_kind !== e.kind) begin
						$display("%0t: access_kind expected %0d actual %0d",
							$time, e.kind, access_kind);
						error_count++;
					end
				end
			end
			pop <= ($urandom_range(99) >= pop_idle_pct);
		end
	end

	// Watchdog: count cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if (arst_n && !stimulus_done) begin
			if ((push && !full) || (pop && !empty)) watchdog <= 0;
			else watchdog <= watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic drain_queues();
		while (pending_accesses.size() > 0 || expected_lookups.size() > 0 || push)
			@(posedge clk);
	endtask

	initial begin
		logic [19:0] tag_pool[8];
		int s;
		arst_n = 1'b0;
		push_idle_pct = 32;
		pop_idle_pct = 54;
		push_hold = 1'b0;
		error_count = 0;
		watchdog = 0;
		beats_in = 0;
		beats_out = 0;
		stimulus_done = 1'b0;
		for (int k = 0; k < 3; k++) kind_seen[k] = 0;
		for (int i = 0; i < sal_pkg::NUM_SETS; i++) begin
			for (int w = 0; w < sal_pkg::NUM_WAYS; w++) begin
				shadow_valid[i][w] = 1'b0;
				shadow_tag[i][w] = '0;
				shadow_rank[i][w] = w;
			end
		end

		// directed: fill a set cold, hit, then force LRU evictions; edge sets and tags
		add_access(6'd0, 20'h00000);
		add_access(6'd0, 20'hFFFFF);
		add_access(6'd0, 20'h55555);
		add_access(6'd0, 20'hAAAAA);
		add_access(6'd0, 20'h00000);
		add_access(6'd0, 20'hFFFFF);
		add_access(6'd0, 20'h12345);
		add_access(6'd0, 20'h55555);
		add_access(6'd0, 20'h6789A);
		add_access(6'd0, 20'h00000);
		add_access(6'd63, 20'hFFFFF);
		add_access(6'd63, 20'hFFFFF);
		add_access(6'd63, 20'h00001);
		add_access(6'd63, 20'h80000);
		add_access(6'd63, 20'h00001);
		add_access(6'd63, 20'h7FFFF);
		add_access(6'd63, 20'hFFFFE);
		add_access(6'd63, 20'hFFFFF);
		add_access(6'd21, 20'h0F0F0);
		add_access(6'd42, 20'h0F0F0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// random: small tag pools per phase so hits, cold and conflict misses all occur
		for (int phase = 0; phase < 3; phase++) begin
			for (int j = 0; j < 8; j++) tag_pool[j] = 20'($urandom);
			for (int n = 0; n < 145; n++) begin
				s = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
				if ($urandom_range(9) == 0) add_access(s[5:0], 20'($urandom));
				else add_access(s[5:0], tag_pool[$urandom_range(7)]);
			end
			drain_queues();
			// once every result is back, hold the sender for a random pause, then switch idling
			push_hold = 1'b1;
			repeat ($urandom_range(20, 5)) @(posedge clk);
			push_hold = 1'b0;
			push_idle_pct = (phase == 0) ? 54 : 0;
			pop_idle_pct = (phase == 0) ? 32 : 0;
		end

		drain_queues();
		stimulus_done = 1'b1;
		repeat (20) @(posedge clk);
		$display("covered %0d accesses, %0d results: %0d hits, %0d cold, %0d conflict",
			beats_in, beats_out, kind_seen[0], kind_seen[1], kind_seen[2]);
		if (error_count == 0 && expected_lookups.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
